/* design/rmat_pkg.sv */
`timescale 1ns / 1ps

package rmat_pkg;

  localparam int RMAT_ENTRIES = 16;

  // Configuration register indexes
  localparam logic CFG_DEFAULT_ACTION  = 1'b0;
  localparam logic CFG_DEFAULT_ENABLED = 1'b1;

  // Item kinds carried on in_tuser
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_MATCHED  = 3'd0,
    ST_DEFAULT  = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_BADORDER = 3'd4,
    ST_OVERLAP  = 3'd5,
    ST_FULL     = 3'd6
  } rmat_status_t;

  // One stored interval
  typedef struct packed {
    logic [7:0] low;
    logic [7:0] high;
    logic [7:0] action;
  } rmat_entry_t;

  // Broadcast to every cell
  typedef struct packed {
    logic [7:0] value;   // lookup value, or lower bound on insert
    logic [7:0] upper;
    logic [7:0] action;
    logic       wr;      // commit an insert this cycle
  } rmat_cmd_t;

  // Per-cell compare results
  typedef struct packed {
    logic       hit;
    logic       overlap;
    logic [7:0] hit_action;  // zero unless hit
  } rmat_stat_t;

endpackage

/* design/rmat_cell.sv */
`timescale 1ns / 1ps

module rmat_cell (
  input  logic                clk,
  input  logic                occupied,
  input  rmat_pkg::rmat_cmd_t cmd,
  input  rmat_pkg::rmat_entry_t left_entry,
  input  logic                left_sel,
  output rmat_pkg::rmat_entry_t entry,
  output logic                sel,
  output rmat_pkg::rmat_stat_t stat
);
  import rmat_pkg::*;

  rmat_entry_t entry_r;
  rmat_entry_t entry_nxt;
  logic        above;

  // Cells whose interval lies above the new one, plus empty cells, form a suffix
  assign above = occupied && (entry_r.low > cmd.upper);
  assign sel   = above || !occupied;
  assign entry = entry_r;

  assign stat.hit        = occupied && (entry_r.low <= cmd.value) && (cmd.value <= entry_r.high);
  assign stat.overlap    = occupied && (cmd.value <= entry_r.high) && (entry_r.low <= cmd.upper);
  assign stat.hit_action = stat.hit ? entry_r.action : 8'd0;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.wr) begin
      if (left_sel) begin
        // shift up behind the insertion point
        entry_nxt = left_entry;
      end else if (sel) begin
        entry_nxt.low    = cmd.value;
        entry_nxt.high   = cmd.upper;
        entry_nxt.action = cmd.action;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* design/range_match_action_table_unit.sv */
`timescale 1ns / 1ps

// Range match action table.
// Holds up to ENTRIES disjoint inclusive byte intervals, sorted by bound, each
// with an 8-bit action id. Input channel (in_*): in_tuser selects lookup (0)
// or insert (1); in_tdata carries value / lower bound, upper bound and action.
// Result channel (out_*): exactly one transfer per input transfer, with the
// status code on out_tuser and the action id on out_tdata.
// Each cell of the chain compares its own interval in parallel, so a lookup or
// an insert (including the shift that keeps the order) completes in the cycle
// the item is accepted. The result is registered, and out_tvalid rises in the next
// cycle; throughput is one item per cycle while out_tready is high, set by the
// single output register. When the receiver stalls, the result holds in the
// output register and in_tready drops until it is taken.
// Configuration (cfg_*): write default_action (index 0) or default_enabled
// (index 1) while the block is idle.
// Reset (rst_n low, synchronous) empties the table, clears the defaults and
// drops out_tvalid; stored interval contents are not cleared.

module range_match_action_table_unit #(
  parameter int ENTRIES = rmat_pkg::RMAT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] value, [15:8] upper_bound, [23:16] action_tag
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result_action
  output logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import rmat_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Configuration
  logic [7:0] dflt_action_r;
  logic       dflt_en_r;

  // Table fill
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Output register
  logic         out_valid_r;
  logic         out_valid_nxt;
  rmat_status_t out_status_r;
  rmat_status_t out_status_nxt;
  logic [7:0]   out_action_r;
  logic [7:0]   out_action_nxt;

  logic          in_fire;
  rmat_cmd_t     cmd;
  rmat_entry_t   chain_entry [ENTRIES+1];
  logic          chain_sel   [ENTRIES+1];
  rmat_stat_t    stat        [ENTRIES];
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] ovl_vec;
  logic [7:0]    hit_action;
  logic          any_hit;
  logic          any_ovl;
  logic          full;
  logic          insert_ok;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full      = (count_r == CNT_W'(ENTRIES));
  assign insert_ok = in_fire && (in_tuser == MODE_INSERT) && (in_tdata[7:0] <= in_tdata[15:8])
                     && !any_ovl && !full;

  assign cmd.value  = in_tdata[7:0];
  assign cmd.upper  = in_tdata[15:8];
  assign cmd.action = in_tdata[23:16];
  assign cmd.wr     = insert_ok;

  // Head of the chain: nothing shifts into cell 0
  assign chain_entry[0] = '0;
  assign chain_sel[0]   = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic occ;
      assign occ = (CNT_W'(gi) < count_r);

      rmat_cell u_cell (
        .clk        (clk),
        .occupied   (occ),
        .cmd        (cmd),
        .left_entry (chain_entry[gi]),
        .left_sel   (chain_sel[gi]),
        .entry      (chain_entry[gi+1]),
        .sel        (chain_sel[gi+1]),
        .stat       (stat[gi])
      );

      assign hit_vec[gi] = stat[gi].hit;
      assign ovl_vec[gi] = stat[gi].overlap;
    end
  endgenerate

  // Intervals are disjoint, so at most one cell hits; OR the masked actions
  always_comb begin
    hit_action = 8'd0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_action = hit_action | stat[i].hit_action;
    end
  end

  assign any_hit = |hit_vec;
  assign any_ovl = |ovl_vec;

  // Result decision for the item being accepted
  always_comb begin
    out_status_nxt = out_status_r;
    out_action_nxt = out_action_r;
    count_nxt      = count_r;
    if (in_fire) begin
      out_action_nxt = 8'd0;
      if (in_tuser == MODE_LOOKUP) begin
        if (any_hit) begin
          out_status_nxt = ST_MATCHED;
          out_action_nxt = hit_action;
        end else if (dflt_en_r) begin
          out_status_nxt = ST_DEFAULT;
          out_action_nxt = dflt_action_r;
        end else begin
          out_status_nxt = ST_NOMATCH;
        end
      end else if (in_tdata[7:0] > in_tdata[15:8]) begin
        out_status_nxt = ST_BADORDER;
      end else if (any_ovl) begin
        out_status_nxt = ST_OVERLAP;
      end else if (full) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_INSERTED;
        count_nxt      = count_r + CNT_W'(1);
      end
    end
  end

  // Load on transfer in, drop once the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      dflt_action_r <= 8'd0;
      dflt_en_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFAULT_ACTION:  dflt_action_r <= cfg_wdata;
          CFG_DEFAULT_ENABLED: dflt_en_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_action_r <= out_action_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_action_r;
  assign out_tuser  = out_status_r;

  // Fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table depth");

  // A successful insert grows the table by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    insert_ok |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance entry count");

  // Stored intervals never overlap, so lookups hit at most one cell
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one interval matched");

  // Action is zero for every status other than matched or default
  a_action_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_MATCHED && out_tuser != ST_DEFAULT) |-> (out_tdata == 8'd0))
    else $error("nonzero action on a non-matching status");

endmodule

/* dv/rmat_checker.sv */
`timescale 1ns / 1ps

module rmat_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] value, [15:8] upper_bound, [23:16] action_tag
  input  logic        in_tuser,   // [0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] result_action
  input  logic [2:0]  out_tuser,  // [2:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          outstanding,
  output int          failures
);
  import rmat_pkg::*;

  typedef struct packed {
    rmat_status_t status;
    logic [7:0]   action;
  } outcome_t;

  rmat_entry_t cells [RMAT_ENTRIES];
  int          used;
  logic [7:0]  dflt_action;
  logic        dflt_en;
  outcome_t    table_outcomes [$];
  outcome_t    want;
  outcome_t    fresh;

  // Apply one item to the shadow table and return the response it should give.
  function automatic outcome_t table_response(logic mode, logic [7:0] v, logic [7:0] ub,
                                              logic [7:0] tag);
    outcome_t o;
    int       i;
    int       pos;
    o.action = '0;
    if (mode == MODE_LOOKUP) begin
      for (i = 0; i < used; i++) begin
        if (cells[i].low <= v && v <= cells[i].high) begin
          o.status = ST_MATCHED;
          o.action = cells[i].action;
          return o;
        end
      end
      if (dflt_en) begin
        o.status = ST_DEFAULT;
        o.action = dflt_action;
      end else begin
        o.status = ST_NOMATCH;
      end
      return o;
    end
    if (v > ub) begin
      o.status = ST_BADORDER;
      return o;
    end
    for (i = 0; i < used; i++) begin
      if (v <= cells[i].high && cells[i].low <= ub) begin
        o.status = ST_OVERLAP;
        return o;
      end
    end
    if (used >= RMAT_ENTRIES) begin
      o.status = ST_FULL;
      return o;
    end
    pos = used;
    for (i = 0; i < used; i++) begin
      if (cells[i].low > ub) begin
        pos = i;
        break;
      end
    end
    for (i = used; i > pos; i--) cells[i] = cells[i - 1];
    cells[pos].low    = v;
    cells[pos].high   = ub;
    cells[pos].action = tag;
    used++;
    o.status = ST_INSERTED;
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      used        = 0;
      dflt_action = '0;
      dflt_en     = 1'b0;
      table_outcomes.delete();
      outstanding = 0;
      failures    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (table_outcomes.size() == 0) begin
          $error("unexpected result: status %0d action %0d", out_tuser, out_tdata);
          failures++;
        end else begin
          want = table_outcomes.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            failures++;
          end
          if (out_tdata !== want.action) begin
            $error("result_action: expected %0d, got %0d", want.action, out_tdata);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = table_response(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
        table_outcomes.insert(table_outcomes.size(), fresh);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_DEFAULT_ACTION) dflt_action = cfg_wdata;
        else if (cfg_index == CFG_DEFAULT_ENABLED) dflt_en = cfg_wdata[0];
      end
      outstanding = table_outcomes.size();
    end
  end

endmodule

/* dv/range_match_action_table_unit_tb.sv */
`timescale 1ns / 1ps

module range_match_action_table_unit_tb;
  import rmat_pkg::*;

  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 220;
  localparam int IDLE_PCT        = 18;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;           // [7:0] value, [15:8] upper_bound, [23:16] action_tag
  logic        in_tuser   = MODE_LOOKUP;  // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;                 // [7:0] result_action
  logic [2:0]  out_tuser;                 // [2:0] status
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_DEFAULT_ACTION;
  logic [7:0]  cfg_wdata  = '0;

  int outstanding;
  int failures;
  int cycles = 0;

  // Shared knobs: the stimulus process sets them, the receiver only reads them.
  bit calm        = 1'b0;  // no idling on either side
  bit squeeze_req = 1'b0;  // ask the receiver for one long hold-off

  range_match_action_table_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rmat_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random back-pressure, none while calm, and one long hold-off on
  // request so the output register fills and the block drops in_tready.
  initial begin
    bit squeeze_done;
    squeeze_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
        out_tready <= 1'b1;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it; return at the edge of
  // its transfer. tvalid stays high for a back-to-back follower.
  task automatic offer_item(logic mode, logic [7:0] v, logic [7:0] ub, logic [7:0] tag);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {tag, ub, v};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and wait until every expected result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] tag;
    int         w;
    int         pick;
    int         insert_pct;
    bit         en;

    // Hold reset from time zero, release it once and never again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default action set but disabled: misses must report no match, action zero.
    write_reg(CFG_DEFAULT_ACTION, 8'h5A);
    write_reg(CFG_DEFAULT_ENABLED, 8'h00);

    // Directed: empty table lookups, bound ordering, single-byte intervals,
    // overlaps on a shared edge, sorted placement, hits at both interval ends.
    offer_item(MODE_LOOKUP, 8'h00, 8'hFF, 8'hFF);
    offer_item(MODE_LOOKUP, 8'hFF, 8'h00, 8'h00);
    offer_item(MODE_INSERT, 8'hFF, 8'h00, 8'hFF);  // out of order
    offer_item(MODE_INSERT, 8'h00, 8'h00, 8'hFF);  // one-value interval at zero
    offer_item(MODE_INSERT, 8'hFF, 8'hFF, 8'h00);  // one-value interval at top
    offer_item(MODE_INSERT, 8'd16, 8'd31, 8'h5A);
    offer_item(MODE_INSERT, 8'd31, 8'd40, 8'h11);  // shares the upper edge
    offer_item(MODE_INSERT, 8'd0,  8'd5,  8'h22);  // covers the zero interval
    offer_item(MODE_INSERT, 8'd10, 8'd15, 8'h33);  // lands between stored ones
    offer_item(MODE_INSERT, 8'd1,  8'd0,  8'h44);  // out of order by one
    offer_item(MODE_INSERT, 8'd200, 8'd254, 8'h80);
    offer_item(MODE_INSERT, 8'd0,  8'd255, 8'hC3); // spans everything
    offer_item(MODE_LOOKUP, 8'd0,   8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd255, 8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd16,  8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd31,  8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd15,  8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd32,  8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd254, 8'd0, 8'd0);
    offer_item(MODE_LOOKUP, 8'd199, 8'd0, 8'd0);
    drain();

    // Enable the default and miss a few times.
    write_reg(CFG_DEFAULT_ACTION, 8'hC3);
    write_reg(CFG_DEFAULT_ENABLED, 8'h01);
    offer_item(MODE_LOOKUP, 8'd128, 8'hFF, 8'hFF);
    offer_item(MODE_LOOKUP, 8'd9,   8'hFF, 8'hFF);
    drain();

    // Random phases, each under its own default setting. Early phases lean on
    // inserts to fill the table; later ones probe it with lookups and run
    // into the full and overlap rejections.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tag = 8'hFF;           en = 1'b1; end
        1: begin tag = 8'h00;           en = 1'b1; end
        2: begin tag = 8'($urandom);    en = 1'b0; end
        3: begin tag = 8'($urandom);    en = 1'b1; end
        4: begin tag = 8'($urandom);    en = 1'b1; end
        default: begin tag = 8'hFF;     en = 1'b0; end
      endcase
      write_reg(CFG_DEFAULT_ACTION, tag);
      // Only bit 0 of the enable write counts; vary the rest.
      write_reg(CFG_DEFAULT_ENABLED, {7'($urandom), en});

      calm        = (p == 1);
      squeeze_req = (p == 3);
      insert_pct  = (p < 3) ? 35 : 20;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        lo  = 8'($urandom);
        hi  = 8'($urandom);
        tag = 8'($urandom);
        if ($urandom_range(99) < insert_pct) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            // Well-formed interval, mostly narrow so many fit in the table.
            w  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
            hi = (lo + w > 255) ? 8'hFF : 8'(lo + w);
          end else if (pick < 85) begin
            lo = 8'($urandom_range(255, 1));
            hi = 8'($urandom_range(lo - 1, 0));
          end
          offer_item(MODE_INSERT, lo, hi, tag);
        end else begin
          if ($urandom_range(9) == 0) lo = $urandom_range(1) ? 8'hFF : 8'h00;
          offer_item(MODE_LOOKUP, lo, hi, tag);
        end
      end
      drain();
    end

    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
design/rmat_pkg.sv
design/rmat_cell.sv
design/range_match_action_table_unit.sv
dv/rmat_checker.sv
dv/range_match_action_table_unit_tb.sv
